[hw/rtl/plenc_pkg.sv]
// Shared types and constants of the plaintext encode/decode block.
package plenc_pkg;

  localparam int VW  = 64;  // value width
  localparam int QW  = 63;  // ciphertext modulus width
  localparam int PW  = 21;  // plaintext space width
  localparam int TW  = 23;  // ticks width (4p)
  localparam int ETW = 2;   // encoding type width
  localparam int CIW = 2;   // config index width

  typedef enum logic [ETW-1:0] {
    ENC_FULL        = 2'd0,
    ENC_PARTIAL     = 2'd1,
    ENC_SSHORT      = 2'd2,
    ENC_SSHORT_BAL  = 2'd3
  } enc_type_t;

  localparam logic [CIW-1:0] CFG_ENC_TYPE = 2'd0;
  localparam logic [CIW-1:0] CFG_PTXT     = 2'd1;
  localparam logic [CIW-1:0] CFG_MODULUS  = 2'd2;

  localparam logic MODE_ENCODE = 1'b0;
  localparam logic MODE_DECODE = 1'b1;

endpackage

[hw/rtl/plenc_if.sv]
// Request and result channel interfaces.
interface plenc_req_if;
  import plenc_pkg::*;
  logic                 valid;
  logic                 ready;
  logic                 mode;
  logic signed [VW-1:0] value_in;
  modport source(output valid, mode, value_in, input ready);
  modport sink(input valid, mode, value_in, output ready);
endinterface

interface plenc_res_if;
  import plenc_pkg::*;
  logic                 valid;
  logic                 ready;
  logic signed [VW-1:0] value_out;
  modport source(output valid, value_out, input ready);
  modport sink(input valid, value_out, output ready);
endinterface

[hw/rtl/plenc_scale_div.sv]
// Sequential divider for scale = floor(q / ticks), rerun after each config write.
module plenc_scale_div (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 load,
  input  logic [plenc_pkg::QW-1:0] q,
  input  logic [plenc_pkg::TW-1:0] t,
  output logic [plenc_pkg::QW-1:0] scale,
  output logic                 busy
);
  import plenc_pkg::*;

  localparam int CW = $clog2(QW);

  logic          running;
  logic [CW-1:0] cnt;
  logic [TW-1:0] rem;
  logic [QW-1:0] quo;
  logic [TW:0]   trial;
  logic [TW:0]   diff;

  assign trial = {rem, quo[QW-1]};
  assign diff  = trial - {1'b0, t};

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      cnt     <= '0;
    end else if (load) begin
      running <= 1'b1;
      cnt     <= '0;
    end else if (running) begin
      cnt <= cnt + 1'b1;
      if (cnt == CW'(QW - 1)) running <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      quo <= q;
      rem <= '0;
    end else if (running) begin
      if (trial >= {1'b0, t}) begin
        rem <= diff[TW-1:0];
        quo <= {quo[QW-2:0], 1'b1};
      end else begin
        rem <= trial[TW-1:0];
        quo <= {quo[QW-2:0], 1'b0};
      end
    end
  end

  assign scale = quo;
  assign busy  = load | running;

endmodule

[hw/rtl/plenc_pdiv.sv]
// Pipelined restoring divider, one quotient bit per stage, with sideband.
module plenc_pdiv #(
  parameter int NW = 128,
  parameter int DW = 63,
  parameter int SW = 2
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  logic          in_vld,
  input  logic [NW-1:0] in_num,
  input  logic [SW-1:0] in_side,
  input  logic [DW-1:0] div,
  output logic          out_vld,
  output logic [NW-1:0] out_quo,
  output logic [DW-1:0] out_rem,
  output logic [SW-1:0] out_side
);

  logic          vld      [NW];
  logic [DW-1:0] rem      [NW];
  logic [NW-1:0] num      [NW];
  logic [SW-1:0] side     [NW];
  logic [DW-1:0] rem_next [NW];
  logic [NW-1:0] num_next [NW];

  function automatic logic [DW+NW-1:0] div_step(logic [DW-1:0] r, logic [NW-1:0] n,
                                                logic [DW-1:0] d);
    logic [DW:0] trial;
    logic [DW:0] diff;
    trial = {r, n[NW-1]};
    diff  = trial - {1'b0, d};
    if (trial >= {1'b0, d}) return {diff[DW-1:0], n[NW-2:0], 1'b1};
    return {trial[DW-1:0], n[NW-2:0], 1'b0};
  endfunction

  always_comb begin
    {rem_next[0], num_next[0]} = div_step('0, in_num, div);
    for (int i = 1; i < NW; i++) begin
      {rem_next[i], num_next[i]} = div_step(rem[i-1], num[i-1], div);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NW; i++) vld[i] <= 1'b0;
    end else if (en) begin
      vld[0] <= in_vld;
      for (int i = 1; i < NW; i++) vld[i] <= vld[i-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side[0] <= in_side;
      for (int i = 1; i < NW; i++) side[i] <= side[i-1];
      for (int i = 0; i < NW; i++) begin
        rem[i] <= rem_next[i];
        num[i] <= num_next[i];
      end
    end
  end

  assign out_vld  = vld[NW-1];
  assign out_quo  = num[NW-1];
  assign out_rem  = rem[NW-1];
  assign out_side = side[NW-1];

endmodule

[hw/rtl/fhe_plaintext_encode_decode.sv]
// Plaintext scaling encoder/decoder: one request per cycle while ready is high.
// Each request (encode or decode of a 64-bit value) yields one result after an
// input register, 32x32 partial products, their sum, 128 stages dividing by q,
// two rounding/mapping stages, 88 stages dividing by p or the tick count, and a
// final register. A one-entry skid buffer at the output lets the pipeline take
// one more request while a result waits. After reset and after every configuration
// write, floor(q/ticks) is recomputed by a bit-serial divider, during which no
// request is taken.
module fhe_plaintext_encode_decode (
  input  logic                      clk,
  input  logic                      rst,
  plenc_req_if.sink                 request,
  plenc_res_if.source               result,
  input  logic                      cfg_we,
  input  logic [plenc_pkg::CIW-1:0] cfg_index,
  input  logic [plenc_pkg::QW-1:0]  cfg_data
);
  import plenc_pkg::*;

  localparam int NW1 = 128;
  localparam int NW2 = 88;
  localparam int SW2 = VW + 2;

  // configuration
  enc_type_t     enc_type;
  logic [PW-1:0] ptxt;
  logic [QW-1:0] modulus;
  logic [TW-1:0] ticks;
  logic          load;
  logic          busy;
  logic [QW-1:0] scale;
  logic [QW-1:0] scale_eff;
  logic          zero_cfg;
  logic [TW-1:0] div2_d;

  always_ff @(posedge clk) begin
    if (rst) begin
      enc_type <= ENC_FULL;
      ptxt     <= PW'(4);
      modulus  <= QW'(64'h1_0000_0000);
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_ENC_TYPE: enc_type <= enc_type_t'(cfg_data[ETW-1:0]);
        CFG_PTXT:     ptxt     <= cfg_data[PW-1:0];
        CFG_MODULUS:  modulus  <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) load <= 1'b1;
    else     load <= cfg_we;
  end

  always_comb begin
    case (enc_type)
      ENC_FULL:    ticks = {2'b00, ptxt};
      ENC_PARTIAL: ticks = {1'b0, ptxt, 1'b0};
      default:     ticks = {ptxt, 2'b00};
    endcase
  end

  plenc_scale_div u_sdiv (
    .clk   (clk),
    .rst   (rst),
    .load  (load),
    .q     (modulus),
    .t     (ticks),
    .scale (scale),
    .busy  (busy)
  );

  // ticks of one means scale = q, which is 0 mod q
  assign scale_eff = (ticks == TW'(1)) ? '0 : scale;
  assign zero_cfg  = (modulus == '0) || (ticks == '0);
  assign div2_d    = (enc_type == ENC_SSHORT) ? ticks : {2'b00, ptxt};

  // flow control
  logic          en;
  logic          skid_vld;
  logic [VW-1:0] skid_val;
  logic          last_vld;
  logic [VW-1:0] last_val;

  assign en            = !skid_vld;
  assign request.ready = en && !busy && !cfg_we;

  // stage 0: magnitude and multiplier select
  logic          s0_vld;
  logic          s0_mode;
  logic          s0_neg;
  logic [VW-1:0] s0_mag;
  logic [QW-1:0] s0_k;

  always_ff @(posedge clk) begin
    if (rst)     s0_vld <= 1'b0;
    else if (en) s0_vld <= request.valid && request.ready;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s0_mode <= request.mode;
      s0_neg  <= request.value_in[VW-1];
      s0_mag  <= request.value_in[VW-1] ? VW'(-request.value_in) : VW'(request.value_in);
      s0_k    <= (request.mode == MODE_DECODE) ? {{(QW-TW){1'b0}}, ticks} : scale_eff;
    end
  end

  // stage 1: partial products
  logic          s1_vld;
  logic          s1_mode;
  logic          s1_neg;
  logic [63:0]   pp00, pp01, pp10, pp11;

  always_ff @(posedge clk) begin
    if (rst)     s1_vld <= 1'b0;
    else if (en) s1_vld <= s0_vld;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_mode <= s0_mode;
      s1_neg  <= s0_neg;
      pp00    <= s0_mag[31:0]  * s0_k[31:0];
      pp01    <= s0_mag[31:0]  * {1'b0, s0_k[QW-1:32]};
      pp10    <= s0_mag[63:32] * s0_k[31:0];
      pp11    <= s0_mag[63:32] * {1'b0, s0_k[QW-1:32]};
    end
  end

  // stage 2: product sum
  logic           s2_vld;
  logic           s2_mode;
  logic           s2_neg;
  logic [NW1-1:0] s2_prod;

  always_ff @(posedge clk) begin
    if (rst)     s2_vld <= 1'b0;
    else if (en) s2_vld <= s1_vld;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_mode <= s1_mode;
      s2_neg  <= s1_neg;
      s2_prod <= {64'b0, pp00} + {32'b0, pp01, 32'b0} + {32'b0, pp10, 32'b0}
               + {pp11, 64'b0};
    end
  end

  // divide by q
  logic           d1_vld;
  logic [NW1-1:0] d1_quo;
  logic [QW-1:0]  d1_rem;
  logic [1:0]     d1_side;

  plenc_pdiv #(.NW(NW1), .DW(QW), .SW(2)) u_div1 (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_vld   (s2_vld),
    .in_num   (s2_prod),
    .in_side  ({s2_mode, s2_neg}),
    .div      (modulus),
    .out_vld  (d1_vld),
    .out_quo  (d1_quo),
    .out_rem  (d1_rem),
    .out_side (d1_side)
  );

  // stage 3: rounding and encode result
  logic           s3_vld;
  logic           s3_mode;
  logic           s3_neg;
  logic [NW2-1:0] s3_m;
  logic [VW-1:0]  s3_enc;
  logic           rnd;

  assign rnd = d1_rem >= (modulus - d1_rem);

  always_ff @(posedge clk) begin
    if (rst)     s3_vld <= 1'b0;
    else if (en) s3_vld <= d1_vld;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s3_mode <= d1_side[1];
      s3_neg  <= d1_side[0];
      s3_m    <= d1_quo[NW2-1:0] + NW2'(rnd);
      s3_enc  <= d1_side[0] ? -{1'b0, d1_rem} : {1'b0, d1_rem};
    end
  end

  // stage 4: early results (encode, zero, balanced low range)
  logic           s4_vld;
  logic           s4_neg;
  logic           s4_use_pre;
  logic [VW-1:0]  s4_pre;
  logic [NW2-1:0] s4_m;
  logic           bal_low;
  logic [VW-1:0]  bal_val;

  assign bal_low = (enc_type == ENC_SSHORT_BAL) && (s3_neg || (s3_m < {67'b0, ptxt}));
  assign bal_val = (s3_neg ? -s3_m[VW-1:0] : s3_m[VW-1:0]) - {43'b0, ptxt};

  always_ff @(posedge clk) begin
    if (rst)     s4_vld <= 1'b0;
    else if (en) s4_vld <= s3_vld;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s4_neg <= s3_neg;
      s4_m   <= s3_m;
      if (zero_cfg) begin
        s4_use_pre <= 1'b1;
        s4_pre     <= '0;
      end else if (s3_mode == MODE_ENCODE) begin
        s4_use_pre <= 1'b1;
        s4_pre     <= s3_enc;
      end else if (s3_m == '0) begin
        s4_use_pre <= 1'b1;
        s4_pre     <= '0;
      end else begin
        s4_use_pre <= bal_low;
        s4_pre     <= bal_val;
      end
    end
  end

  // divide m by p, or by ticks for signed short
  logic           d2_vld;
  logic [NW2-1:0] d2_quo;
  logic [TW-1:0]  d2_rem;
  logic [SW2-1:0] d2_side;

  plenc_pdiv #(.NW(NW2), .DW(TW), .SW(SW2)) u_div2 (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_vld   (s4_vld),
    .in_num   (s4_m),
    .in_side  ({s4_neg, s4_use_pre, s4_pre}),
    .div      (div2_d),
    .out_vld  (d2_vld),
    .out_quo  (d2_quo),
    .out_rem  (d2_rem),
    .out_side (d2_side)
  );

  // final mapping
  logic          f_neg;
  logic          f_use_pre;
  logic [TW-1:0] rr;
  logic [VW-1:0] final_val;
  logic          unused_quo;

  assign f_neg      = d2_side[SW2-1];
  assign f_use_pre  = d2_side[SW2-2];
  assign unused_quo = ^d2_quo;
  assign rr         = (f_neg && d2_rem != '0) ? (ticks - d2_rem) : d2_rem;

  always_comb begin
    if (f_use_pre) begin
      final_val = d2_side[VW-1:0];
    end else begin
      case (enc_type)
        ENC_FULL, ENC_PARTIAL:
          final_val = f_neg ? -{41'b0, d2_rem} : {41'b0, d2_rem};
        ENC_SSHORT:
          final_val = ({rr, 1'b0} >= {1'b0, ticks}) ? ({41'b0, rr} - {41'b0, ticks})
                                                    : {41'b0, rr};
        default:
          final_val = {41'b0, d2_rem};
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst)     last_vld <= 1'b0;
    else if (en) last_vld <= d2_vld;
  end

  always_ff @(posedge clk) begin
    if (en) last_val <= final_val ^ {{(VW-1){1'b0}}, unused_quo & 1'b0};
  end

  // skid buffer
  always_ff @(posedge clk) begin
    if (rst) begin
      skid_vld <= 1'b0;
    end else if (skid_vld) begin
      if (result.ready) skid_vld <= 1'b0;
    end else if (last_vld && !result.ready) begin
      skid_vld <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!skid_vld) skid_val <= last_val;
  end

  assign result.valid     = skid_vld | last_vld;
  assign result.value_out = skid_vld ? skid_val : last_val;

  a_cfg_busy: assert property (@(posedge clk) disable iff (rst) cfg_we |=> busy)
    else $error("scale divider not restarted after config write");

  a_skid_hold: assert property (@(posedge clk) disable iff (rst)
      skid_vld && !result.ready |=> skid_vld && $stable(skid_val))
    else $error("skid entry lost while output stalled");

  a_pipe_freeze: assert property (@(posedge clk) disable iff (rst)
      skid_vld |=> $stable(last_vld))
    else $error("pipeline advanced while skid full");

endmodule
